### src/psr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types, constants and the CRC-32 byte update for the PSI section
// reassembler.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam logic [7:0]  PACKET_BYTES  = 8'd188;
  localparam logic [7:0]  POS_MAX       = 8'd255;
  localparam logic [7:0]  POS_PUSI      = 8'd1;
  localparam logic [7:0]  POS_POINTER   = 8'd4;
  localparam logic [8:0]  SECTION_BASE  = 9'd5;
  localparam int unsigned PUSI_BIT      = 6;
  localparam logic [12:0] HEADER_BYTES  = 13'd3;
  localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_start;
  } psr_in_t;

  typedef struct packed {
    logic [7:0]  section_byte;
    logic [12:0] section_offset;
    logic        section_end;
    logic        crc_good;
  } psr_out_t;

  // msb-first crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### src/psr_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psr_in_reg
// Input register: holds one transaction until the parser consumes it.
// ----------------------------------------------------------------------------
module psr_in_reg
  import psr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire psr_in_t in_data,
  input  wire logic    advance,
  output logic         vld,
  output psr_in_t      data
);

  logic    vld_r;
  logic    vld_nxt;
  psr_in_t data_r;
  psr_in_t data_nxt;

  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (in_ready) begin
      vld_nxt  = in_valid;
      data_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign vld  = vld_r;
  assign data = data_r;

endmodule
`default_nettype wire

### src/psr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psr_core
// Packet framing, section tracking and CRC-32 check; one byte per cycle while en is high.
// ----------------------------------------------------------------------------
module psr_core
  import psr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire psr_in_t    item,
  input  wire logic [7:0] wanted_tid,
  output logic            res_vld,
  output psr_out_t        res
);

  logic [7:0]  pos_r,       pos_nxt;
  logic        start_r,     start_nxt;
  logic [7:0]  ptr_r,       ptr_nxt;
  logic        collect_r,   collect_nxt;
  logic        drop_r,      drop_nxt;
  logic [12:0] total_r,     total_nxt;
  logic [12:0] taken_r,     taken_nxt;
  logic [31:0] crc_r,       crc_nxt;
  logic        take;
  logic        last;
  logic [31:0] crc_calc;
  logic [7:0]  b;

  assign b = item.packet_byte;

  always_comb begin
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    ptr_nxt     = ptr_r;
    collect_nxt = collect_r;
    drop_nxt    = drop_r;
    total_nxt   = total_r;
    taken_nxt   = taken_r;
    crc_nxt     = crc_r;
    take        = 1'b0;
    last        = 1'b0;
    crc_calc    = crc_byte(crc_r, b);
    if (en) begin
      if (item.packet_start) begin
        pos_nxt  = '0;
        drop_nxt = 1'b0;
      end else begin
        pos_nxt = (pos_r != POS_MAX) ? pos_r + 8'd1 : pos_r;
        if (pos_nxt >= PACKET_BYTES) begin
          take = 1'b0;
        end else if (pos_nxt == POS_PUSI) begin
          start_nxt = b[PUSI_BIT];
        end else if (pos_nxt >= POS_POINTER && !drop_r) begin
          if (!collect_r) begin
            if (pos_nxt == POS_POINTER) begin
              if (start_r) begin
                ptr_nxt = b;
              end else begin
                drop_nxt = 1'b1;
              end
            end else if ({1'b0, pos_nxt} == ({1'b0, ptr_r} + SECTION_BASE)) begin
              if (b != wanted_tid) begin
                drop_nxt = 1'b1;
              end else begin
                collect_nxt = 1'b1;
                take        = 1'b1;
              end
            end
          end else if (!(pos_nxt == POS_POINTER && start_r)) begin
            take = 1'b1;
          end
        end
      end
      if (take) begin
        crc_nxt = crc_calc;
        if (taken_r == 13'd1) begin
          total_nxt = {1'b0, b[3:0], 8'h00};
        end else if (taken_r == 13'd2) begin
          total_nxt = HEADER_BYTES + (total_r | {5'b0, b});
        end
        taken_nxt = taken_r + 13'd1;
        if (taken_r >= 13'd2 && taken_nxt >= total_nxt) begin
          last        = 1'b1;
          collect_nxt = 1'b0;
          total_nxt   = '0;
          taken_nxt   = '0;
          crc_nxt     = CRC_INIT;
          drop_nxt    = 1'b1;
        end
      end
    end
  end

  assign res_vld            = take;
  assign res.section_byte   = b;
  assign res.section_offset = taken_r;
  assign res.section_end    = last;
  assign res.crc_good       = last && (crc_calc == 32'h0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      start_r   <= 1'b0;
      ptr_r     <= '0;
      collect_r <= 1'b0;
      drop_r    <= 1'b0;
      total_r   <= '0;
      taken_r   <= '0;
      crc_r     <= CRC_INIT;
    end else begin
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      ptr_r     <= ptr_nxt;
      collect_r <= collect_nxt;
      drop_r    <= drop_nxt;
      total_r   <= total_nxt;
      taken_r   <= taken_nxt;
      crc_r     <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

### src/psi_section_reassembler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psi_section_reassembler
// the path from input transaction to result valid runs through the input register,
//   then the result register; throughput: one byte per cycle unless the output stalls
// the single-pass parser updates its counters and crc-32 together for each byte
// reset: synchronous active-low rst_n clears control state and table id
// ----------------------------------------------------------------------------
module psi_section_reassembler
  import psr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire psr_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output psr_out_t        out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic       stg_vld;
  psr_in_t    stg_data;
  logic       advance;
  logic       res_vld;
  psr_out_t   res;
  logic [7:0] tid_r;
  logic       out_valid_r, out_valid_nxt;
  psr_out_t   out_data_r,  out_data_nxt;

  assign advance = stg_vld && (!out_valid_r || out_ready);

  psr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .vld      (stg_vld),
    .data     (stg_data)
  );

  psr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .item       (stg_data),
    .wanted_tid (tid_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && res_vld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tid_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tid_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### test/psr_section_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psr_section_check
// Watches both channels and the table id port of the section reassembler,
// predicts every section byte from the accepted stream bytes and compares
// each result transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
package psr_tb_pkg;

  import psr_pkg::CRC_POLY;

  // bit-serial mpeg-2 crc-32, msb first
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ d[i];
      c  = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

module psr_section_check
  import psr_pkg::*;
  import psr_tb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  psr_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  psr_out_t out_data,
  input  logic     cfg_we,
  input  logic     [7:0] cfg_wdata,
  output int       fails,
  output int       waiting
);

  logic [7:0]  match_tid;
  logic [7:0]  pkt_pos;
  logic        pusi;
  logic [7:0]  ptr;
  logic        in_section;
  logic        skip_packet;
  logic [12:0] sec_total;
  logic [12:0] taken;
  logic [31:0] crc;

  psr_out_t sections_q[$];
  psr_out_t want;
  psr_out_t made;
  int       fail_total = 0;
  int       pending_n  = 0;

  assign fails   = fail_total;
  assign waiting = pending_n;

  task automatic report(input string what, input int got, input int expd);
    $display("%0t section check: %s, got %0h expected %0h", $time, what, got, expd);
    fail_total = fail_total + 1;
  endtask

  function automatic void leave_section();
    in_section = 1'b0;
    sec_total  = '0;
    taken      = '0;
    crc        = CRC_INIT;
  endfunction

  // advances the parser by one stream byte; returns 1 when a section byte comes out
  function automatic bit take_byte(input psr_in_t item, output psr_out_t res);
    logic [7:0]  b;
    logic [12:0] offs;
    b = item.packet_byte;
    if (item.packet_start) begin
      pkt_pos     = '0;
      skip_packet = 1'b0;
      return 1'b0;
    end
    if (pkt_pos != POS_MAX) begin
      pkt_pos = pkt_pos + 8'd1;
    end
    if (pkt_pos >= PACKET_BYTES) return 1'b0;
    if (pkt_pos == POS_PUSI) begin
      pusi = b[PUSI_BIT];
      return 1'b0;
    end
    if (pkt_pos < POS_POINTER || skip_packet) return 1'b0;
    if (!in_section) begin
      if (pkt_pos == POS_POINTER) begin
        if (pusi) begin
          ptr = b;
        end else begin
          skip_packet = 1'b1;
        end
        return 1'b0;
      end
      if ({1'b0, pkt_pos} != SECTION_BASE + {1'b0, ptr}) return 1'b0;
      if (b != match_tid) begin
        skip_packet = 1'b1;
        return 1'b0;
      end
      in_section = 1'b1;
    end else if (pkt_pos == POS_POINTER && pusi) begin
      return 1'b0;
    end
    offs = taken;
    crc  = crc32_step(crc, b);
    if (offs == 13'd1) begin
      sec_total = {1'b0, b[3:0], 8'h00};
    end else if (offs == 13'd2) begin
      sec_total = HEADER_BYTES + (sec_total | {5'd0, b});
    end
    taken = offs + 13'd1;
    res.section_byte   = b;
    res.section_offset = offs;
    res.section_end    = 1'b0;
    res.crc_good       = 1'b0;
    if (offs >= 13'd2 && taken >= sec_total) begin
      res.section_end = 1'b1;
      res.crc_good    = (crc == 32'd0);
      leave_section();
      skip_packet = 1'b1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      match_tid   = '0;
      pkt_pos     = '0;
      pusi        = 1'b0;
      ptr         = '0;
      skip_packet = 1'b0;
      leave_section();
      sections_q.delete();
      pending_n <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sections_q.size() == 0) begin
          report("result with no transaction pending", int'(out_data.section_byte), 0);
        end else begin
          want = sections_q.pop_front();
          if (out_data.section_byte !== want.section_byte)
            report("section_byte", int'(out_data.section_byte),
                   int'(want.section_byte));
          if (out_data.section_offset !== want.section_offset)
            report("section_offset", int'(out_data.section_offset),
                   int'(want.section_offset));
          if (out_data.section_end !== want.section_end)
            report("section_end", int'(out_data.section_end), int'(want.section_end));
          if (out_data.crc_good !== want.crc_good)
            report("crc_good", int'(out_data.crc_good), int'(want.crc_good));
        end
      end
      if (cfg_we) begin
        match_tid = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        if (take_byte(in_data, made)) begin
          sections_q.push_back(made);
        end
      end
      pending_n <= sections_q.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives transport stream packets carrying psi sections, with good and bad
// crc, wrong table ids, odd pointers, short and long packets and noise, into
// the reassembler over several table id settings; the section check does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  import psr_pkg::*;
  import psr_tb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF    = 400;
  localparam int PHASE_ITEMS = 330;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  psr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  psr_out_t out_data;
  logic     cfg_we    = 1'b0;
  logic     [7:0] cfg_wdata = 8'h00;

  int         fail_count;
  int         waiting_count;
  int         idle_cycles = 0;
  int         items_sent  = 0;
  int         burst_left  = 40;
  bit         choke_req   = 1'b0;
  logic [7:0] wanted      = 8'h00;
  logic [7:0] sec_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  psi_section_reassembler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  psr_section_check section_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fails     (fail_count),
    .waiting   (waiting_count)
  );

  // one stream byte per transaction, in bursts with random gaps
  task automatic put_byte(input logic [7:0] b, input logic s);
    int gap;
    int r;
    in_valid <= 1'b1;
    in_data  <= '{packet_byte: b, packet_start: s};
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      r = $urandom_range(0, 99);
      if (r < 40) burst_left = $urandom_range(1, 6);
      else if (r < 85) burst_left = $urandom_range(16, 120);
      else burst_left = $urandom_range(200, 600);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_plen();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(6, 48);
    if (r < 95) return 188;
    return $urandom_range(189, 270);
  endfunction

  // one packet; section bytes from sec_q fill it from data_at onwards
  task automatic ts_packet(input int plen, input bit pusi, input int data_at,
                           input logic [7:0] b4);
    logic [7:0] b;
    for (int p = 0; p < plen; p++) begin
      if (p == 0) begin
        put_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h47, 1'b1);
      end else if (p == 1) begin
        b = 8'($urandom);
        b[PUSI_BIT] = pusi;
        put_byte(b, 1'b0);
      end else if (p == POS_POINTER && data_at > POS_POINTER) begin
        put_byte(b4, 1'b0);
      end else if (p >= data_at && sec_q.size() != 0) begin
        put_byte(sec_q.pop_front(), 1'b0);
      end else begin
        put_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic send_section(input logic [7:0] tid, input int len, input bit corrupt,
                              input bit broken);
    logic [31:0] c;
    int          ptr;
    int          plen;
    int          r;
    bit          pusi;
    sec_q.delete();
    sec_q.push_back(tid);
    sec_q.push_back({4'($urandom), 4'(len >> 8)});
    sec_q.push_back(8'(len));
    if (len < 4) begin
      repeat (len) sec_q.push_back(8'($urandom));
    end else begin
      repeat (len - 4) sec_q.push_back(8'($urandom));
      c = CRC_INIT;
      foreach (sec_q[i]) c = crc32_step(c, sec_q[i]);
      sec_q.push_back(c[31:24]);
      sec_q.push_back(c[23:16]);
      sec_q.push_back(c[15:8]);
      sec_q.push_back(c[7:0]);
    end
    if (corrupt) begin
      r = $urandom_range(3, sec_q.size() - 1);
      sec_q[r] = sec_q[r] ^ (8'd1 << $urandom_range(0, 7));
    end
    r = $urandom_range(0, 99);
    if (r < 70) ptr = 0;
    else if (r < 90) ptr = $urandom_range(1, 3);
    else ptr = $urandom_range(0, 255);
    plen = pick_plen();
    ts_packet(plen, 1'b1, 5 + ptr, 8'(ptr));
    if (5 + ptr >= plen || 5 + ptr >= PACKET_BYTES || broken) sec_q.delete();
    while (sec_q.size() != 0) begin
      pusi = ($urandom_range(0, 3) == 0);
      ts_packet(pick_plen(), pusi, pusi ? 5 : 4, 8'($urandom));
    end
  endtask

  task automatic run_phase(input int n);
    int start_n;
    int r;
    int len;
    start_n = items_sent;
    while (items_sent - start_n < n) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      if (len < 60) len = $urandom_range(0, 24);
      else if (len < 95) len = $urandom_range(25, 180);
      else len = $urandom_range(181, 700);
      if (r < 65) begin
        send_section(wanted, len, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
      end else if (r < 80) begin
        send_section(wanted ^ 8'($urandom_range(1, 255)), len, 1'b0, 1'b0);
      end else begin
        ts_packet($urandom_range(1, 40), 1'($urandom_range(0, 1)), 5,
                  8'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_table(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    wanted     = v;
  endtask

  // receiver: changing ready patterns, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    mode_left = 0;
    mode = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left = mode_left - 1;
      if (choke_req) begin
        choke_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    psr_in_t    opening[$];
    logic [7:0] tids[4];
    opening = '{
      // stream starting without a mark, three-byte section
      '{8'h40, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
      '{8'h00, 1'b0}, '{8'hF0, 1'b0}, '{8'h00, 1'b0},
      // pointer beyond the packet
      '{8'h47, 1'b1}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
      // no unit start while idle
      '{8'hFF, 1'b1}, '{8'hBF, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h12, 1'b0},
      // short first packet, continued in a packet with unit start set
      '{8'h47, 1'b1}, '{8'h40, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
      '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h04, 1'b0},
      '{8'h47, 1'b1}, '{8'h40, 1'b0}, '{8'hAA, 1'b0}, '{8'h55, 1'b0}, '{8'h33, 1'b0},
      '{8'h01, 1'b0}, '{8'h02, 1'b0}, '{8'h03, 1'b0}, '{8'h04, 1'b0}
    };
    tids = '{8'hFF, 8'($urandom), 8'h00, 8'($urandom)};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_table(8'h00);
    foreach (opening[i]) put_byte(opening[i].packet_byte, opening[i].packet_start);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_table(tids[ph]);
      if (ph == 1) choke_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();
    end
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### psi_section_reassembler.f
src/psr_pkg.sv
src/psr_in_reg.sv
src/psr_core.sv
src/psi_section_reassembler.sv
test/psr_section_check.sv
test/tb.sv
